@@ rtl/assert_macros.svh @@
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i outside reset.
`define VIE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define VIE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

@@ rtl/vie_pkg.sv @@
// Shared types and constants of the vole instruction executor.
package vie_pkg;

  // Register file size and index width.
  localparam int REG_COUNT = 16;
  localparam int REG_AW = $clog2(REG_COUNT);

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_WRITE_MEM = 2'd0,
    OP_EXECUTE   = 2'd1,
    OP_READ_MEM  = 2'd2,
    OP_READ_REG  = 2'd3
  } op_e;

  // Instruction opcodes (upper nibble of the instruction word).
  localparam logic [3:0] OPC_LOAD  = 4'h1;
  localparam logic [3:0] OPC_LDI   = 4'h2;
  localparam logic [3:0] OPC_STORE = 4'h3;
  localparam logic [3:0] OPC_MOVE  = 4'h4;
  localparam logic [3:0] OPC_ADD   = 4'h5;
  localparam logic [3:0] OPC_ADD2  = 4'h6;
  localparam logic [3:0] OPC_JUMP  = 4'hB;
  localparam logic [3:0] OPC_HALT  = 4'hC;

  // Access request to the word memory.
  typedef struct packed {
    logic        re;
    logic [7:0]  raddr;
    logic        we;
    logic [7:0]  waddr;
    logic [15:0] wdata;
  } word_req_t;

  // Access request to the register file: two read ports, one write port.
  typedef struct packed {
    logic              re_a;
    logic [REG_AW-1:0] raddr_a;
    logic              re_b;
    logic [REG_AW-1:0] raddr_b;
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [7:0]        wdata;
  } rf_req_t;

endpackage

@@ rtl/vie_ifs.sv @@
// Handshake interfaces for the command and result channels.
interface vie_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  address;
  logic [15:0] write_data;

  modport source (output valid, operation, address, write_data, input ready);
  modport sink (input valid, operation, address, write_data, output ready);
endinterface

interface vie_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [8:0]  program_counter;
  logic        halted;
  logic        fault;

  modport source (output valid, read_data, program_counter, halted, fault, input ready);
  modport sink (input valid, read_data, program_counter, halted, fault, output ready);
endinterface

@@ rtl/vie_word_mem.sv @@
// Word memory: synchronous read, one write port, valid bits and write forwarding.
module vie_word_mem import vie_pkg::*; #(
  parameter int MEM_WORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  word_req_t   req_i,
  output logic [15:0] rdata_o
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [8:0] Depth = 9'(MEM_WORDS);

  logic [15:0]          mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;
  logic                 rd_in, wr_en;
  logic [AW-1:0]        ridx, widx;
  logic [15:0]          rd_q, fwd_q;
  logic                 use_fwd_q, zero_q;

  // Address range checks; out-of-range reads give zero, writes are dropped.
  assign rd_in = ({1'b0, req_i.raddr} < Depth);
  assign wr_en = req_i.we && ({1'b0, req_i.waddr} < Depth);
  assign ridx  = rd_in ? req_i.raddr[AW-1:0] : '0;
  assign widx  = wr_en ? req_i.waddr[AW-1:0] : '0;

  // Storage array and its registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[widx] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q  <= mem_q[ridx];
      fwd_q <= req_i.wdata;
    end
  end

  // Valid bits and read selection flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      use_fwd_q <= 1'b0;
      zero_q    <= 1'b1;
    end else begin
      if (wr_en) begin
        vld_q[widx] <= 1'b1;
      end
      if (req_i.re) begin
        use_fwd_q <= wr_en && (req_i.waddr == req_i.raddr);
        zero_q    <= !rd_in || !vld_q[ridx];
      end
    end
  end

  // A read that met a write to the same word returns the new data.
  assign rdata_o = use_fwd_q ? fwd_q : (zero_q ? 16'h0000 : rd_q);

endmodule

@@ rtl/vie_reg_file.sv @@
// Register file: two synchronous read ports, one write port, write forwarding.
module vie_reg_file import vie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rf_req_t    req_i,
  output logic [7:0] rdata_a_o,
  output logic [7:0] rdata_b_o
);

  logic [7:0]           rf_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [7:0]           rd_a_q, rd_b_q, fwd_a_q, fwd_b_q;
  logic                 sel_fwd_a_q, sel_fwd_b_q, zero_a_q, zero_b_q;

  // Storage array and registered read ports.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      rf_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re_a) begin
      rd_a_q  <= rf_q[req_i.raddr_a];
      fwd_a_q <= req_i.wdata;
    end
    if (req_i.re_b) begin
      rd_b_q  <= rf_q[req_i.raddr_b];
      fwd_b_q <= req_i.wdata;
    end
  end

  // Valid bits stand in for the cleared reset contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      sel_fwd_a_q <= 1'b0;
      sel_fwd_b_q <= 1'b0;
      zero_a_q    <= 1'b1;
      zero_b_q    <= 1'b1;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re_a) begin
        sel_fwd_a_q <= req_i.we && (req_i.waddr == req_i.raddr_a);
        zero_a_q    <= !vld_q[req_i.raddr_a];
      end
      if (req_i.re_b) begin
        sel_fwd_b_q <= req_i.we && (req_i.waddr == req_i.raddr_b);
        zero_b_q    <= !vld_q[req_i.raddr_b];
      end
    end
  end

  assign rdata_a_o = sel_fwd_a_q ? fwd_a_q : (zero_a_q ? 8'h00 : rd_a_q);
  assign rdata_b_o = sel_fwd_b_q ? fwd_b_q : (zero_b_q ? 8'h00 : rd_b_q);

endmodule

@@ rtl/vole_instruction_executor.sv @@
// Top level of the vole instruction executor: control, execute step and result register.
//
//   Channel   Direction  Item
//   item_i    in         operation, address, write_data
//   result_o  out        read_data, program_counter, halted, fault
//
// A memory or register access item completes in the fetch phase, an execute item
// goes through the fetch and execute phases: in the fetch phase the fetched
// instruction word issues the operand and data reads, in the execute phase the
// instruction executes and its result is written back. The registered read
// port of the word memory sets this split, since the data address is known
// only once the instruction word has been read. The next item is taken in the
// cycle an item completes. Reset clears the valid bits of both stores at once,
// so no clearing pass is needed. A full result register stalls completion.
`include "assert_macros.svh"

module vole_instruction_executor import vie_pkg::*; #(
  parameter int MEM_WORDS = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  vie_cmd_if.sink    item_i,
  vie_rsp_if.source  result_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FETCH = 2'd1;
  localparam logic [1:0] PH_EXEC  = 2'd2;
  localparam logic [8:0] MemEnd   = 9'(MEM_WORDS);

  logic [1:0]  phase_q, phase_d;
  op_e         op_q, in_op;
  logic [7:0]  addr_q;
  logic [15:0] wdata_q, ir_q;
  logic [8:0]  pc_q, pc_d;
  logic        halted_q, halted_d, fault_q, fault_d;

  logic        accept, fin, out_free, fetch_exec;
  word_req_t   wreq;
  rf_req_t     rreq;
  logic [15:0] mem_rdata;
  logic [7:0]  rf_a, rf_b;

  logic [3:0]  f_opc;
  logic [3:0]  opc, r_f, y_f;
  logic [7:0]  xy;
  logic [8:0]  ex_pc, ex_next;
  logic        ex_halt, ex_fault, ex_adv, ex_mem_we, ex_rf_we;
  logic [3:0]  ex_rf_wa;
  logic [7:0]  ex_rf_wd;

  logic        out_valid_q;
  logic [15:0] out_rdata_q, fin_rdata;
  logic [8:0]  out_pc_q;
  logic        out_halt_q, out_fault_q;

  // Handshake and phase control.
  assign in_op      = op_e'(item_i.operation);
  assign out_free   = !out_valid_q || result_o.ready;
  assign fin        = out_free && ((phase_q == PH_EXEC) ||
                      ((phase_q == PH_FETCH) && (op_q != OP_EXECUTE)));
  assign item_i.ready = (phase_q == PH_IDLE) || fin;
  assign accept     = item_i.valid && item_i.ready;
  assign fetch_exec = (phase_q == PH_FETCH) && (op_q == OP_EXECUTE);

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = PH_FETCH;
    end else if (fetch_exec) begin
      phase_d = PH_EXEC;
    end else if (fin) begin
      phase_d = PH_IDLE;
    end
  end

  // Execute step: decodes the fetched instruction with its operands.
  assign opc = ir_q[15:12];
  assign r_f = ir_q[11:8];
  assign y_f = ir_q[3:0];
  assign xy  = ir_q[7:0];

  always_comb begin
    ex_pc     = pc_q;
    ex_halt   = halted_q;
    ex_fault  = fault_q;
    ex_adv    = 1'b0;
    ex_mem_we = 1'b0;
    ex_rf_we  = 1'b0;
    ex_rf_wa  = r_f;
    ex_rf_wd  = 8'h00;
    ex_next   = pc_q + 9'd1;
    if (!halted_q) begin
      if (pc_q >= MemEnd) begin
        ex_halt = 1'b1;
      end else if (ir_q == 16'h0000) begin
        ex_halt = 1'b1;
      end else begin
        unique case (opc)
          OPC_HALT: begin
            ex_halt = 1'b1;
          end
          OPC_LOAD: begin
            ex_rf_we = 1'b1;
            ex_rf_wd = mem_rdata[7:0];
            ex_adv   = 1'b1;
          end
          OPC_LDI: begin
            ex_rf_we = 1'b1;
            ex_rf_wd = xy;
            ex_adv   = 1'b1;
          end
          OPC_STORE: begin
            ex_mem_we = 1'b1;
            ex_adv    = 1'b1;
          end
          OPC_MOVE: begin
            ex_rf_we = 1'b1;
            ex_rf_wa = y_f;
            ex_rf_wd = rf_a;
            ex_adv   = 1'b1;
          end
          OPC_ADD, OPC_ADD2: begin
            ex_rf_we = 1'b1;
            ex_rf_wd = rf_a + rf_b;
            ex_adv   = 1'b1;
          end
          OPC_JUMP: begin
            if (rf_a == rf_b) begin
              ex_next = {1'b0, xy};
            end
            ex_adv = 1'b1;
          end
          default: begin
            ex_halt  = 1'b1;
            ex_fault = 1'b1;
          end
        endcase
      end
    end
    if (ex_adv) begin
      ex_pc = ex_next;
      if (ex_next >= MemEnd) begin
        ex_halt = 1'b1;
      end
    end
  end

  // Machine state after this cycle, also used to fetch for a new item.
  always_comb begin
    pc_d     = pc_q;
    halted_d = halted_q;
    fault_d  = fault_q;
    if (fin && (phase_q == PH_EXEC)) begin
      pc_d     = ex_pc;
      halted_d = ex_halt;
      fault_d  = ex_fault;
    end
  end

  // Word memory requests: fetch or data read, and write-back at completion.
  always_comb begin
    wreq.re    = accept || fetch_exec;
    if (fetch_exec) begin
      wreq.raddr = mem_rdata[7:0];
    end else if (in_op == OP_EXECUTE) begin
      wreq.raddr = pc_d[7:0];
    end else begin
      wreq.raddr = item_i.address;
    end
    wreq.we    = fin && (((phase_q == PH_FETCH) && (op_q == OP_WRITE_MEM)) ||
                         ((phase_q == PH_EXEC) && ex_mem_we));
    wreq.waddr = (phase_q == PH_FETCH) ? addr_q : xy;
    wreq.wdata = (phase_q == PH_FETCH) ? wdata_q : {8'h00, rf_a};
  end

  // Register file requests: item register reads, operand select from the fetched word, and write-back.
  assign f_opc = mem_rdata[15:12];

  always_comb begin
    rreq.re_a    = accept || fetch_exec;
    rreq.re_b    = fetch_exec;
    if (fetch_exec) begin
      if ((f_opc == OPC_MOVE) || (f_opc == OPC_ADD) || (f_opc == OPC_ADD2)) begin
        rreq.raddr_a = mem_rdata[7:4];
      end else begin
        rreq.raddr_a = mem_rdata[11:8];
      end
    end else begin
      rreq.raddr_a = item_i.address[REG_AW-1:0];
    end
    rreq.raddr_b = (f_opc == OPC_JUMP) ? '0 : mem_rdata[3:0];
    rreq.we      = fin && (phase_q == PH_EXEC) && ex_rf_we;
    rreq.waddr   = ex_rf_wa;
    rreq.wdata   = ex_rf_wd;
  end

  vie_word_mem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_word_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (wreq),
    .rdata_o(mem_rdata)
  );

  vie_reg_file u_reg_file (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (rreq),
    .rdata_a_o(rf_a),
    .rdata_b_o(rf_b)
  );

  // Item fields and the fetched instruction word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      addr_q  <= item_i.address;
      wdata_q <= item_i.write_data;
    end
    if (fetch_exec) begin
      ir_q <= mem_rdata;
    end
  end

  // Read data of a completing item.
  always_comb begin
    fin_rdata = 16'h0000;
    if (phase_q == PH_FETCH) begin
      case (op_q)
        OP_READ_MEM: fin_rdata = mem_rdata;
        OP_READ_REG: fin_rdata = {8'h00, rf_a};
        default:     fin_rdata = 16'h0000;
      endcase
    end
  end

  // Control state and machine state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
      fault_q  <= fault_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_rdata_q <= fin_rdata;
      out_pc_q    <= pc_d;
      out_halt_q  <= halted_d;
      out_fault_q <= fault_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.read_data       = out_rdata_q;
  assign result_o.program_counter = out_pc_q;
  assign result_o.halted          = out_halt_q;
  assign result_o.fault           = out_fault_q;

  // Checks on the machine state.
  `VIE_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halt flag cleared without reset")
  `VIE_ASSERT(a_fault_halts, fault_q |-> halted_q, "fault set while running")
  `VIE_ASSERT(a_pc_moves_on_exec, !$stable(pc_q) |-> ($past(phase_q) == PH_EXEC), "pc changed outside execute")
  `VIE_ASSERT_ALWAYS(a_one_read_source, !(accept && fetch_exec), "item taken during a fetch")

endmodule

@@ bench/vole_instruction_executor_test.sv @@
// Self-checking testbench of the vole instruction executor: directed table, random programs, halts.
module vole_instruction_executor_test;
  import vie_pkg::*;

  localparam int MEM_WORDS = 256;
  // At or above this address a program is steered back with an always-taken jump.
  localparam logic [8:0] PC_WRAP_LIMIT = 9'd240;
  // Opcodes that decode to no instruction.
  localparam logic [3:0] OPC_UNUSED [8] = '{4'h0, 4'h7, 4'h8, 4'h9, 4'hA, 4'hD, 4'hE, 4'hF};
  localparam int PHASE_ITEMS = 330;

  // Ways the machine can be brought to a stop at the end of the run.
  typedef enum logic [1:0] {
    STOP_ZERO_WORD,
    STOP_HALT_OP,
    STOP_BAD_OPCODE,
    STOP_PAST_END
  } stop_kind_e;

  typedef struct packed {
    logic [15:0] read_data;
    logic [8:0]  program_counter;
    logic        halted;
    logic        fault;
  } vole_result_t;

  typedef struct {
    op_e          op;
    logic [7:0]   addr;
    logic [15:0]  wdata;
    bit           typed;
    vole_result_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  vie_cmd_if item_bus ();
  vie_rsp_if result_bus ();

  vole_instruction_executor #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  // Mirror of the machine state.
  logic [15:0] mem_image [MEM_WORDS];
  logic [7:0]  reg_image [REG_COUNT];
  logic [8:0]  pc_image;
  logic        halted_image;
  logic        fault_image;

  vole_result_t pending_results [$];
  vole_result_t oldest_result;
  stim_row_t    directed_rows [$];
  int           error_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Applies one item to the state mirror and returns the result it should produce.
  function automatic vole_result_t vole_step(op_e op, logic [7:0] addr, logic [15:0] wdata);
    vole_result_t res;
    logic [15:0] word;
    logic [3:0]  opc;
    logic [3:0]  rn;
    logic [3:0]  xn;
    logic [3:0]  yn;
    logic [7:0]  xy;
    logic [9:0]  next_pc;
    bit          bad;
    res = '0;
    case (op)
      OP_WRITE_MEM: mem_image[addr] = wdata;
      OP_READ_MEM:  res.read_data = mem_image[addr];
      OP_READ_REG:  res.read_data = {8'h00, reg_image[addr[3:0]]};
      default: begin
        if (!halted_image) begin
          if (pc_image >= MEM_WORDS) begin
            halted_image = 1'b1;
          end else begin
            word = mem_image[pc_image[7:0]];
            opc = word[15:12];
            rn = word[11:8];
            xn = word[7:4];
            yn = word[3:0];
            xy = word[7:0];
            next_pc = {1'b0, pc_image} + 10'd1;
            bad = 1'b0;
            if (word == 16'h0000 || opc == OPC_HALT) begin
              halted_image = 1'b1;
            end else begin
              case (opc)
                OPC_LOAD:  reg_image[rn] = mem_image[xy][7:0];
                OPC_LDI:   reg_image[rn] = xy;
                OPC_STORE: mem_image[xy] = {8'h00, reg_image[rn]};
                OPC_MOVE:  reg_image[yn] = reg_image[xn];
                OPC_ADD, OPC_ADD2: reg_image[rn] = reg_image[xn] + reg_image[yn];
                OPC_JUMP: begin
                  if (reg_image[rn] == reg_image[0]) next_pc = {2'b00, xy};
                end
                default: bad = 1'b1;
              endcase
              if (bad) begin
                halted_image = 1'b1;
                fault_image = 1'b1;
              end else begin
                pc_image = next_pc[8:0];
                if (next_pc >= MEM_WORDS) halted_image = 1'b1;
              end
            end
          end
        end
      end
    endcase
    res.program_counter = pc_image;
    res.halted = halted_image;
    res.fault = fault_image;
    return res;
  endfunction

  // Drives one item and waits until it is taken; call at a rising edge.
  task automatic send_item(op_e op, logic [7:0] addr, logic [15:0] wdata,
                           bit typed = 1'b0, vole_result_t typed_res = '0);
    vole_result_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    predicted = vole_step(op, addr, wdata);
    pending_results.push_back(typed ? typed_res : predicted);
    item_bus.valid <= 1'b1;
    item_bus.operation <= op;
    item_bus.address <= addr;
    item_bus.write_data <= wdata;
    do @(posedge clk_i); while (!item_bus.ready);
  endtask

  // Lowers valid and waits until every outstanding result has come back.
  task automatic hold_until_drained();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // A random instruction that cannot stop the machine when run at the given address.
  function automatic logic [15:0] make_instr(logic [8:0] at);
    logic [3:0]  opc;
    logic [11:0] body;
    body = 12'($urandom);
    if (at >= PC_WRAP_LIMIT) return {OPC_JUMP, 4'h0, 8'($urandom_range(0, 239))};
    case ($urandom_range(6))
      0: opc = OPC_LOAD;
      1: opc = OPC_LDI;
      2: opc = OPC_STORE;
      3: opc = OPC_MOVE;
      4: opc = OPC_ADD;
      5: opc = OPC_ADD2;
      default: begin
        opc = OPC_JUMP;
        if ($urandom_range(1) == 0) body[11:8] = 4'h0;
      end
    endcase
    return {opc, body};
  endfunction

  // One idling setting: mostly running programs, with noise accesses mixed in.
  task automatic run_random_phase(int idle_pct, int stall_pct);
    int          pick;
    logic [15:0] word;
    bit          runnable;
    hold_until_drained();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // Run the word at the program counter, replacing it when it would stop the machine.
        word = mem_image[pc_image[7:0]];
        runnable = word != 16'h0000 &&
                   word[15:12] inside {OPC_LOAD, OPC_LDI, OPC_STORE, OPC_MOVE, OPC_ADD,
                                       OPC_ADD2, OPC_JUMP} &&
                   (pc_image < PC_WRAP_LIMIT || word[15:8] == {OPC_JUMP, 4'h0});
        if (!runnable || $urandom_range(1) == 0)
          send_item(OP_WRITE_MEM, pc_image[7:0], make_instr(pc_image));
        send_item(OP_EXECUTE, 8'($urandom), 16'($urandom));
      end else if (pick < 65) begin
        send_item(OP_WRITE_MEM, 8'($urandom), 16'($urandom));
      end else if (pick < 75) begin
        send_item(OP_WRITE_MEM, 8'($urandom), make_instr(9'($urandom_range(0, 255))));
      end else if (pick < 87) begin
        send_item(OP_READ_MEM, 8'($urandom), 16'($urandom));
      end else begin
        send_item(OP_READ_REG, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic add_row(op_e op, logic [7:0] addr, logic [15:0] wdata,
                         bit typed = 1'b0, vole_result_t res = '0);
    stim_row_t row;
    row.op = op;
    row.addr = addr;
    row.wdata = wdata;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  // Result receiver: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          oldest_result = pending_results.pop_front();
          if (result_bus.read_data !== oldest_result.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      result_bus.read_data, oldest_result.read_data));
          if (result_bus.program_counter !== oldest_result.program_counter)
            report_mismatch($sformatf("program_counter %h, expected %h",
                                      result_bus.program_counter,
                                      oldest_result.program_counter));
          if (result_bus.halted !== oldest_result.halted)
            report_mismatch($sformatf("halted %b, expected %b",
                                      result_bus.halted, oldest_result.halted));
          if (result_bus.fault !== oldest_result.fault)
            report_mismatch($sformatf("fault %b, expected %b",
                                      result_bus.fault, oldest_result.fault));
        end
      end
      result_bus.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus.
  initial begin
    vole_result_t idle_res;
    stop_kind_e   stop_kind;
    logic [3:0]   bad_opc;
    logic [11:0]  bad_body;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (mem_image[i]) mem_image[i] = '0;
    foreach (reg_image[i]) reg_image[i] = '0;
    pc_image = '0;
    halted_image = 1'b0;
    fault_image = 1'b0;
    rst_ni = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.operation = OP_WRITE_MEM;
    item_bus.address = '0;
    item_bus.write_data = '0;
    idle_res = '0;

    // Directed program: every instruction kind but halt, jump taken and not taken.
    add_row(OP_READ_REG, 8'h00, 16'hFFFF, 1'b1, idle_res);
    add_row(OP_READ_MEM, 8'hFF, 16'h0000, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h00, {OPC_LDI, 4'h1, 8'hFF}, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h01, {OPC_LDI, 4'h2, 8'h01}, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h02, {OPC_ADD, 4'h3, 4'h1, 4'h2}, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h03, {OPC_ADD2, 4'h4, 4'h1, 4'h1}, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h04, {OPC_STORE, 4'h1, 8'hFF}, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h05, {OPC_LOAD, 4'h5, 8'hFF}, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h06, {OPC_MOVE, 4'h0, 4'h1, 4'h6}, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h07, {OPC_JUMP, 4'h3, 8'h0A}, 1'b1, idle_res);
    add_row(OP_WRITE_MEM, 8'h0A, {OPC_JUMP, 4'h1, 8'hF0}, 1'b1, idle_res);
    repeat (9) add_row(OP_EXECUTE, 8'h00, 16'h0000);
    add_row(OP_READ_REG, 8'h41, 16'h0000, 1'b1, '{16'h00FF, 9'h00B, 1'b0, 1'b0});
    add_row(OP_READ_MEM, 8'hFF, 16'h0000, 1'b1, '{16'h00FF, 9'h00B, 1'b0, 1'b0});
    add_row(OP_WRITE_MEM, 8'hFF, 16'hFFFF, 1'b1, '{16'h0000, 9'h00B, 1'b0, 1'b0});
    add_row(OP_READ_MEM, 8'hFF, 16'h0000, 1'b1, '{16'hFFFF, 9'h00B, 1'b0, 1'b0});
    add_row(OP_READ_REG, 8'hF6, 16'h0000);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].wdata,
                directed_rows[i].typed, directed_rows[i].res);

    run_random_phase(0, 0);
    run_random_phase(61, 0);
    run_random_phase(0, 61);
    run_random_phase(16, 16);

    // Bring the machine to a stop in one of its ways, then poke it while stopped.
    hold_until_drained();
    send_idle_pct = 16;
    recv_stall_pct = 16;
    stop_kind = stop_kind_e'($urandom_range(3));
    case (stop_kind)
      STOP_ZERO_WORD: send_item(OP_WRITE_MEM, pc_image[7:0], 16'h0000);
      STOP_HALT_OP:   send_item(OP_WRITE_MEM, pc_image[7:0], {OPC_HALT, 12'($urandom)});
      STOP_BAD_OPCODE: begin
        bad_opc = OPC_UNUSED[$urandom_range(7)];
        bad_body = 12'($urandom_range(1, 4095));
        send_item(OP_WRITE_MEM, pc_image[7:0], {bad_opc, bad_body});
      end
      default: begin
        // Jump to the last cell, then run a plain instruction there.
        send_item(OP_WRITE_MEM, pc_image[7:0], {OPC_JUMP, 4'h0, 8'hFF});
        send_item(OP_EXECUTE, 8'h00, 16'h0000);
        send_item(OP_WRITE_MEM, 8'hFF, {OPC_LDI, 12'($urandom)});
      end
    endcase
    send_item(OP_EXECUTE, 8'h00, 16'h0000);
    repeat (3) send_item(OP_EXECUTE, 8'($urandom), 16'($urandom));
    send_item(OP_WRITE_MEM, 8'h80, 16'($urandom));
    send_item(OP_READ_MEM, 8'h80, 16'h0000);
    send_item(OP_READ_REG, 8'($urandom), 16'h0000);

    hold_until_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
